// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that requires a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/owtsc_pkg.sv
// ---------------------------------------------------------------------------
// owtsc_pkg
// Types, constants and the CRC-8 step for the scratchpad check unit.
// ---------------------------------------------------------------------------
package owtsc_pkg;

  localparam int unsigned POS_W  = 4;
  localparam int unsigned FRAC_W = 14;
  localparam int unsigned INT_W  = 7;

  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [15:0] TEMP_SIGN_MASK = 16'hF800;
  localparam logic [15:0] TEMP_INT_MASK  = 16'h07F0;
  localparam logic [15:0] TEMP_FRAC_MASK = 16'h000F;
  localparam logic [FRAC_W-1:0] FRAC_SCALE = 14'd625;

  localparam logic [POS_W-1:0] BYTE_TEMP_LOW  = 4'd0;
  localparam logic [POS_W-1:0] BYTE_TEMP_HIGH = 4'd1;
  localparam logic [POS_W-1:0] BYTE_ALARM_HI  = 4'd2;
  localparam logic [POS_W-1:0] BYTE_ALARM_LO  = 4'd3;
  localparam logic [POS_W-1:0] BYTE_CONFIG    = 4'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_read;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_raw;
    logic               crc_error;
    logic               sign_negative;
    logic [INT_W-1:0]   integer_part;
    logic [FRAC_W-1:0]  fraction_part;
    logic [7:0]         alarm_high_byte;
    logic [7:0]         alarm_low_byte;
    logic [7:0]         config_byte;
  } out_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/onewire_temp_scratchpad_check_unit.sv
// ---------------------------------------------------------------------------
// onewire_temp_scratchpad_check_unit
// Checks the CRC-8 of a sensor scratchpad read-back and decodes the temperature.
// ---------------------------------------------------------------------------
// An item is accepted in every cycle unless a finished result is held by out_stall.
// The result appears in the output register in the cycle after the last byte is accepted.
// The CRC step and temperature decode are one pass of logic between those registers.
// Reset leaves the unit idle, waiting for a start, with CRC and byte holds at zero.
module onewire_temp_scratchpad_check_unit
  import owtsc_pkg::*;
#(
  parameter int unsigned SCRATCHPAD_LENGTH = 9
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SCRATCHPAD_LENGTH - 1);
  localparam logic [POS_W-1:0] IDLE_POS = POS_W'(SCRATCHPAD_LENGTH);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       crc_r, crc_nxt, crc_cur;
  logic [7:0]       temp_low_r, temp_low_nxt;
  logic [7:0]       temp_high_r, temp_high_nxt;
  logic [7:0]       alarm_hi_r, alarm_hi_nxt;
  logic [7:0]       alarm_lo_r, alarm_lo_nxt;
  logic [7:0]       config_r, config_nxt;
  logic             out_valid_r;
  out_t             out_data_r, out_data_nxt;
  logic             in_fire, emit;
  logic [15:0]      raw, mag;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    pos_cur       = in_data.start_of_read ? '0 : pos_r;
    crc_cur       = in_data.start_of_read ? '0 : crc_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_low_nxt  = temp_low_r;
    temp_high_nxt = temp_high_r;
    alarm_hi_nxt  = alarm_hi_r;
    alarm_lo_nxt  = alarm_lo_r;
    config_nxt    = config_r;
    emit          = 1'b0;
    if (in_fire && (pos_cur < IDLE_POS)) begin
      case (pos_cur)
        BYTE_TEMP_LOW:  temp_low_nxt  = in_data.data_byte;
        BYTE_TEMP_HIGH: temp_high_nxt = in_data.data_byte;
        BYTE_ALARM_HI:  alarm_hi_nxt  = in_data.data_byte;
        BYTE_ALARM_LO:  alarm_lo_nxt  = in_data.data_byte;
        BYTE_CONFIG:    config_nxt    = in_data.data_byte;
        default: ;
      endcase
      pos_nxt = pos_cur + POS_W'(1);
      if (pos_cur == LAST_POS) begin
        crc_nxt = crc_cur;
        emit    = 1'b1;
      end else begin
        crc_nxt = crc8_update(crc_cur, in_data.data_byte);
      end
    end

    raw = {temp_high_nxt, temp_low_nxt};
    mag = raw[15] ? (~raw + 16'd1) : raw;
    out_data_nxt.temperature_raw = $signed(raw);
    out_data_nxt.crc_error       = (crc_cur != in_data.data_byte);
    out_data_nxt.sign_negative   = |(raw & TEMP_SIGN_MASK);
    out_data_nxt.integer_part    = INT_W'((mag & TEMP_INT_MASK) >> 4);
    out_data_nxt.fraction_part   = FRAC_W'(mag & TEMP_FRAC_MASK) * FRAC_SCALE;
    out_data_nxt.alarm_high_byte = alarm_hi_nxt;
    out_data_nxt.alarm_low_byte  = alarm_lo_nxt;
    out_data_nxt.config_byte     = config_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= IDLE_POS;
      crc_r       <= '0;
      temp_low_r  <= '0;
      temp_high_r <= '0;
      alarm_hi_r  <= '0;
      alarm_lo_r  <= '0;
      config_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_low_r  <= temp_low_nxt;
      temp_high_r <= temp_high_nxt;
      alarm_hi_r  <= alarm_hi_nxt;
      alarm_lo_r  <= alarm_lo_nxt;
      config_r    <= config_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/owtsc_checker.sv
// ---------------------------------------------------------------------------
// owtsc_checker
// Port-level assertions for the scratchpad check unit, bound into every instance of it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module owtsc_checker
  import owtsc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic        out_held;
  logic [15:0] temp_raw;
  logic        sign_ok;
  logic        decode_ok;

  assign out_held  = out_valid && out_stall;
  assign temp_raw  = out_data.temperature_raw;
  assign sign_ok   = out_data.sign_negative == (temp_raw[15:11] != 5'd0);
  assign decode_ok = temp_raw[15] ||
                     ((out_data.integer_part == temp_raw[10:4]) &&
                      (out_data.fraction_part == FRAC_W'(temp_raw[3:0]) * FRAC_SCALE));

  `ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_CLK(a_in_stall_src, !in_stall || out_held, "input stalled without a held result")
  `ASSERT_CLK(a_sign, !out_valid || sign_ok, "sign flag mismatch")
  `ASSERT_CLK(a_pos_decode, !out_valid || decode_ok, "positive temperature decode mismatch")

endmodule

bind onewire_temp_scratchpad_check_unit owtsc_checker u_owtsc_checker (.*);

// File: dv/onewire_temp_scratchpad_check_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// onewire_temp_scratchpad_check_unit_test
// Sends scratchpad read-backs, one byte per item, into the check unit. A short
// table of directed bytes comes first. Random reads follow, mostly with a
// correct CRC and with temperatures biased towards the extremes, mixed with
// aborted reads, stray bytes and bad CRCs. Each result is compared field by
// field with a prediction made when the last byte was accepted. The input
// idles and the output stalls at random.
// ---------------------------------------------------------------------------
module onewire_temp_scratchpad_check_unit_test;
  import owtsc_pkg::*;

  localparam int unsigned PAD_LEN     = 9;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } pad_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic [3:0] pad_pos = 4'(PAD_LEN);
  logic [7:0] crc_acc = '0;
  logic [7:0] hold_temp_lo = '0;
  logic [7:0] hold_temp_hi = '0;
  logic [7:0] hold_alarm_hi = '0;
  logic [7:0] hold_alarm_lo = '0;
  logic [7:0] hold_config = '0;

  out_t        expected_results[$];
  pad_row_t    directed_rows[$];
  int unsigned taken_count = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;

  onewire_temp_scratchpad_check_unit #(
    .SCRATCHPAD_LENGTH(PAD_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] crc8_1wire_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  function automatic in_t byte_item(input logic [7:0] b, input logic s);
    in_t it;
    it.data_byte = b;
    it.start_of_read = s;
    return it;
  endfunction

  task automatic absorb_byte(input in_t it, output bit taken, output bit produced,
                             output out_t res);
    logic [3:0]  slot;
    logic [15:0] raw;
    logic [15:0] mag;
    taken = 1'b0;
    produced = 1'b0;
    res = '0;
    if (it.start_of_read) begin
      pad_pos = '0;
      crc_acc = '0;
    end
    slot = pad_pos;
    if (slot < PAD_LEN) begin
      taken = 1'b1;
      case (slot)
        BYTE_TEMP_LOW: hold_temp_lo = it.data_byte;
        BYTE_TEMP_HIGH: hold_temp_hi = it.data_byte;
        BYTE_ALARM_HI: hold_alarm_hi = it.data_byte;
        BYTE_ALARM_LO: hold_alarm_lo = it.data_byte;
        BYTE_CONFIG: hold_config = it.data_byte;
        default: ;
      endcase
      pad_pos = slot + 4'd1;
      if (slot < PAD_LEN - 1) begin
        crc_acc = crc8_1wire_step(crc_acc, it.data_byte);
      end else begin
        raw = {hold_temp_hi, hold_temp_lo};
        mag = raw[15] ? (~raw + 16'd1) : raw;
        res.temperature_raw = raw;
        res.crc_error = (crc_acc != it.data_byte);
        res.sign_negative = |(raw & TEMP_SIGN_MASK);
        res.integer_part = mag[10:4];
        res.fraction_part = FRAC_W'(mag[3:0]) * FRAC_SCALE;
        res.alarm_high_byte = hold_alarm_hi;
        res.alarm_low_byte = hold_alarm_lo;
        res.config_byte = hold_config;
        produced = 1'b1;
      end
    end
  endtask

  task automatic offer(input in_t it, input bit typed, input out_t want);
    bit          taken;
    bit          produced;
    out_t        res;
    int unsigned gap;
    int unsigned r;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    absorb_byte(it, taken, produced, res);
    if (taken) taken_count++;
    if (produced) expected_results.push_back(typed ? want : res);
    gap = 0;
    if (hold_left != 0) begin
      gap = 0;
    end else if (burst_left != 0) begin
      burst_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(20, 80);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 50);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic s, input bit typed, input out_t want);
    pad_row_t row;
    row.item = byte_item(b, s);
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [15:0] pick_temperature();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4: return 16'h07FF;
      5: return 16'h0800;
      6: return 16'hF800;
      7: return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_scratchpad();
    logic [7:0]  pad [PAD_LEN];
    logic [15:0] temp;
    logic [7:0]  crc_sum;
    int unsigned cut;
    temp = pick_temperature();
    pad[0] = temp[7:0];
    pad[1] = temp[15:8];
    crc_sum = '0;
    for (int i = 2; i < PAD_LEN - 1; i++) pad[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < PAD_LEN - 1; i++) crc_sum = crc8_1wire_step(crc_sum, pad[i]);
    pad[PAD_LEN - 1] = crc_sum;
    if ($urandom_range(0, 3) == 0) begin
      pad[PAD_LEN - 1] = crc_sum ^ 8'($urandom_range(1, 255));
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PAD_LEN - 1) : PAD_LEN;
    for (int i = 0; i < cut; i++) offer(byte_item(pad[i], i == 0), 1'b0, '0);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) offer(byte_item(8'($urandom_range(0, 255)), 1'b0), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t ns: result with none expected, temperature_raw %0d", $time,
               int'(got.temperature_raw));
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("temperature_raw", int'(want.temperature_raw), int'(got.temperature_raw));
      check_field("crc_error", int'(want.crc_error), int'(got.crc_error));
      check_field("sign_negative", int'(want.sign_negative), int'(got.sign_negative));
      check_field("integer_part", int'(want.integer_part), int'(got.integer_part));
      check_field("fraction_part", int'(want.fraction_part), int'(got.fraction_part));
      check_field("alarm_high_byte", int'(want.alarm_high_byte), int'(got.alarm_high_byte));
      check_field("alarm_low_byte", int'(want.alarm_low_byte), int'(got.alarm_low_byte));
      check_field("config_byte", int'(want.config_byte), int'(got.config_byte));
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_count >= 300) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_result(out_data);
    if (hold_left != 0) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      free_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 8);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("onewire_temp_scratchpad_check_unit_test failed");
      $finish;
    end
  end

  initial begin
    bit drained;
    drained = 1'b0;

    // Stray bytes before any start, then a read cut short by a fresh start.
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, '0);
    // An all-zero scratchpad carries a zero CRC, so every field is zero.
    add_row(8'h00, 1'b1, 1'b0, '0);
    repeat (PAD_LEN - 2) add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, '0);
    add_row(8'hAA, 1'b0, 1'b0, '0);
    // The most negative temperature, whose magnitude wraps to itself.
    add_row(8'h00, 1'b1, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b0, 1'b0, '0);
    add_row(8'h22, 1'b0, 1'b0, '0);
    add_row(8'h33, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    taken_count = 0;
    while (taken_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        send_scratchpad();
      end else begin
        offer(byte_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0), 1'b0, '0);
      end
      if (!drained && taken_count >= RANDOM_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("onewire_temp_scratchpad_check_unit_test passed");
    end else begin
      $display("onewire_temp_scratchpad_check_unit_test failed");
    end
    $finish;
  end

endmodule
